>>> rtl/stereo_resonant_filter_mix_macros.svh
// assertion macros for the stereo resonant filter mix
`ifndef STEREO_RESONANT_FILTER_MIX_MACROS_SVH
`define STEREO_RESONANT_FILTER_MIX_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/srfm_pkg.sv
// shared types, constants and arithmetic helpers for the resonant filter mix
package srfm_pkg;

    localparam int CHANNELS_DEF = 2;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;
    localparam int STATE_W   = 32;
    localparam int DIFF_W    = STATE_W + 1;
    localparam int MUL_A_W   = STATE_W + 2;
    localparam int MUL_B_W   = CFG_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int SUM_W     = STATE_W + 8;
    localparam int MIX_Q_W   = PROD_W - 2 * FRAC_W;

    localparam logic [CFG_W-1:0]  MIX_ONE  = CFG_W'(64'd1 << FRAC_W);
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));
    localparam logic [PROD_W-1:0] MIX_HALF = PROD_W'(64'd1 << (2 * FRAC_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_CUTOFF     = 3'd0,
        REG_LOW_RESONANCE  = 3'd1,
        REG_HIGH_CUTOFF    = 3'd2,
        REG_HIGH_RESONANCE = 3'd3,
        REG_WET_MIX        = 3'd4
    } reg_idx_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_START = 10'b00_0000_0010,
        ST_LP_A  = 10'b00_0000_0100,
        ST_LP_B  = 10'b00_0000_1000,
        ST_LP_C  = 10'b00_0001_0000,
        ST_HP_A  = 10'b00_0010_0000,
        ST_HP_B  = 10'b00_0100_0000,
        ST_MIX_B = 10'b00_1000_0000,
        ST_MIX_C = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic                      hit;
        logic signed [STATE_W-1:0] val;
    } sat32_t;

    typedef struct packed {
        logic                       hit;
        logic signed [SAMPLE_W-1:0] val;
    } sat16_t;

    // round half up and drop the fraction bits
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = p + RND_HALF;
        return t[PROD_W-1:FRAC_W];
    endfunction

    // clamp to the signed 32-bit range
    function automatic sat32_t sat32(input logic signed [SUM_W-1:0] v);
        sat32_t                   r;
        logic [SUM_W-STATE_W:0]   top;
        top = v[SUM_W-1:STATE_W-1];
        if ((top == '0) || (top == '1))
        begin
            r.hit = 1'b0;
            r.val = v[STATE_W-1:0];
        end
        else
        begin
            r.hit = 1'b1;
            r.val = v[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // clamp to the signed 16-bit sample range
    function automatic sat16_t sat16(input logic signed [MIX_Q_W-1:0] v);
        sat16_t                     r;
        logic [MIX_Q_W-SAMPLE_W:0]  top;
        top = v[MIX_Q_W-1:SAMPLE_W-1];
        if ((top == '0) || (top == '1))
        begin
            r.hit = 1'b0;
            r.val = v[SAMPLE_W-1:0];
        end
        else
        begin
            r.hit = 1'b1;
            r.val = v[MIX_Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/stereo_resonant_filter_mix.sv
// top level of the stereo resonant filter with dry/wet mix
//
// input transaction: in_valid/in_ready carry op (0 low-pass, 1 high-pass), channel and
//   sample_in; in_ready is high only while the sequencer is idle
// output transaction: out_valid/out_ready carry sample_out and clipped, one per input
// configuration: cfg_write with cfg_index/cfg_data writes one coefficient per cycle; the user
//   writes only while no transaction is in flight (not enforced); unknown indexes are ignored
// sequence: low-pass runs START, LP_A, LP_B, LP_C, MIX_B, MIX_C, DONE; high-pass runs
//   START, HP_A, HP_B, MIX_B, MIX_C, DONE; START goes straight to DONE when the stage is
//   disabled (zero cutoff) or the mix is zero; DONE loads the registered out_valid
// a new transaction is taken only once the sequencer is back in idle; the steps share one
//   34x18 signed multiplier with a registered product, used at most once per step
// the output register decouples the sides: a new input is taken while a result waits;
//   if the receiver stalls, the next result is held in the final state until the
//   output register frees up
// reset: coefficients clear, wet mix goes fully wet, all per-channel filter state clears
module stereo_resonant_filter_mix #(
    parameter int CHANNELS = srfm_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [srfm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srfm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic                                 channel,
    input  logic signed [srfm_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [srfm_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 clipped
);

`include "stereo_resonant_filter_mix_macros.svh"

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W = srfm_pkg::SAMPLE_W;
    localparam int STATE_W  = srfm_pkg::STATE_W;
    localparam int CFG_W    = srfm_pkg::CFG_W;
    localparam int FRAC_W   = srfm_pkg::FRAC_W;
    localparam int DIFF_W   = srfm_pkg::DIFF_W;
    localparam int MUL_A_W  = srfm_pkg::MUL_A_W;
    localparam int MUL_B_W  = srfm_pkg::MUL_B_W;
    localparam int PROD_W   = srfm_pkg::PROD_W;
    localparam int RND_W    = srfm_pkg::RND_W;
    localparam int SUM_W    = srfm_pkg::SUM_W;

    // coefficient registers
    logic [srfm_pkg::COEF_W-1:0] low_cutoff_reg;
    logic signed [CFG_W-1:0]     low_resonance_reg;
    logic [srfm_pkg::COEF_W-1:0] high_cutoff_reg;
    logic signed [CFG_W-1:0]     high_resonance_reg;
    logic [CFG_W-1:0]            wet_mix_reg;

    // per-channel filter state
    logic signed [STATE_W-1:0]  low_output_reg      [CHANNELS];
    logic signed [STATE_W-1:0]  low_output_next     [CHANNELS];
    logic signed [STATE_W-1:0]  low_momentum_reg    [CHANNELS];
    logic signed [STATE_W-1:0]  low_momentum_next   [CHANNELS];
    logic signed [SAMPLE_W-1:0] high_last_reg       [CHANNELS];
    logic signed [SAMPLE_W-1:0] high_last_next      [CHANNELS];
    logic signed [STATE_W-1:0]  high_output_reg     [CHANNELS];
    logic signed [STATE_W-1:0]  high_output_next    [CHANNELS];
    logic signed [STATE_W-1:0]  high_momentum_reg   [CHANNELS];
    logic signed [STATE_W-1:0]  high_momentum_next  [CHANNELS];

    // sequencer and working registers
    srfm_pkg::state_t           state_reg, state_next;
    logic                       op_reg, op_next;
    logic [CH_W-1:0]            ch_reg, ch_next;
    logic signed [SAMPLE_W-1:0] samp_reg, samp_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [RND_W-1:0]    term_reg, term_next;
    logic signed [PROD_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                       clip_reg, clip_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                       clipped_reg, clipped_next;

    // shared multiplier operands
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;

    logic [CFG_W-1:0]           mix_eff;
    logic [CFG_W-1:0]           mix_inv;
    logic [srfm_pkg::COEF_W-1:0] cut_sel;
    logic                       bypass;
    logic signed [STATE_W-1:0]  x_val;
    logic signed [STATE_W-1:0]  last_x;
    logic signed [SUM_W-1:0]    sum_hp;
    logic signed [PROD_W-1:0]   mix_total;
    srfm_pkg::sat32_t           sat_a;
    srfm_pkg::sat16_t           sat_o;

    // mix above one acts as fully wet
    assign mix_eff = (wet_mix_reg > srfm_pkg::MIX_ONE) ? srfm_pkg::MIX_ONE : wet_mix_reg;
    assign mix_inv = srfm_pkg::MIX_ONE - mix_eff;
    assign cut_sel = op_reg ? high_cutoff_reg : low_cutoff_reg;
    assign bypass  = (mix_eff == '0) || (cut_sel == '0);

    // sample in state units
    assign x_val  = {samp_reg, {FRAC_W{1'b0}}};
    assign last_x = {high_last_reg[ch_reg], {FRAC_W{1'b0}}};

    assign in_ready   = (state_reg == srfm_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        ch_next            = ch_reg;
        samp_next          = samp_reg;
        diff_next          = diff_reg;
        term_next          = term_reg;
        acc_next           = acc_reg;
        res_next           = res_reg;
        clip_next          = clip_reg;
        low_output_next    = low_output_reg;
        low_momentum_next  = low_momentum_reg;
        high_last_next     = high_last_reg;
        high_output_next   = high_output_reg;
        high_momentum_next = high_momentum_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        sample_out_next    = sample_out_reg;
        clipped_next       = clipped_reg;
        mul_a              = '0;
        mul_b              = '0;
        sum_hp             = '0;
        mix_total          = '0;
        sat_a              = '0;
        sat_o              = '0;

        case (state_reg)
            srfm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    ch_next    = (CHANNELS > 1) ? CH_W'(channel) : '0;
                    samp_next  = sample_in;
                    clip_next  = 1'b0;
                    state_next = srfm_pkg::ST_START;
                end
            end

            srfm_pkg::ST_START:
            begin
                if (bypass)
                begin
                    // disabled stage or dry mix: pass through, state untouched
                    res_next   = samp_reg;
                    clip_next  = 1'b0;
                    state_next = srfm_pkg::ST_DONE;
                end
                else if (!op_reg)
                begin
                    diff_next  = DIFF_W'(x_val) - DIFF_W'(low_output_reg[ch_reg]);
                    state_next = srfm_pkg::ST_LP_A;
                end
                else
                begin
                    sum_hp = SUM_W'(high_output_reg[ch_reg]) + SUM_W'(high_momentum_reg[ch_reg])
                           - SUM_W'(last_x) + SUM_W'(x_val);
                    sat_a  = srfm_pkg::sat32(sum_hp);
                    high_output_next[ch_reg] = sat_a.val;
                    high_last_next[ch_reg]   = samp_reg;
                    clip_next = clip_reg | sat_a.hit;
                    // old momentum times feedback gain
                    mul_a      = MUL_A_W'(high_momentum_reg[ch_reg]);
                    mul_b      = MUL_B_W'(high_resonance_reg);
                    state_next = srfm_pkg::ST_HP_A;
                end
            end

            srfm_pkg::ST_LP_A:
            begin
                mul_a      = MUL_A_W'(diff_reg);
                mul_b      = $signed({2'b00, low_cutoff_reg});
                state_next = srfm_pkg::ST_LP_B;
            end

            srfm_pkg::ST_LP_B:
            begin
                sat_a = srfm_pkg::sat32(SUM_W'(low_momentum_reg[ch_reg])
                                        + SUM_W'(srfm_pkg::rnd16(prod_reg)));
                low_momentum_next[ch_reg] = sat_a.val;
                clip_next  = clip_reg | sat_a.hit;
                mul_a      = MUL_A_W'(diff_reg);
                mul_b      = MUL_B_W'(low_resonance_reg);
                state_next = srfm_pkg::ST_LP_C;
            end

            srfm_pkg::ST_LP_C:
            begin
                sat_a = srfm_pkg::sat32(SUM_W'(low_output_reg[ch_reg])
                                        + SUM_W'(low_momentum_reg[ch_reg])
                                        + SUM_W'(srfm_pkg::rnd16(prod_reg)));
                low_output_next[ch_reg] = sat_a.val;
                clip_next  = clip_reg | sat_a.hit;
                // dry part of the mix
                mul_a      = MUL_A_W'(x_val);
                mul_b      = $signed({1'b0, mix_inv});
                state_next = srfm_pkg::ST_MIX_B;
            end

            srfm_pkg::ST_HP_A:
            begin
                term_next  = srfm_pkg::rnd16(prod_reg);
                mul_a      = MUL_A_W'(high_output_reg[ch_reg]);
                mul_b      = $signed({2'b00, high_cutoff_reg});
                state_next = srfm_pkg::ST_HP_B;
            end

            srfm_pkg::ST_HP_B:
            begin
                sat_a = srfm_pkg::sat32(SUM_W'(term_reg) - SUM_W'(srfm_pkg::rnd16(prod_reg)));
                high_momentum_next[ch_reg] = sat_a.val;
                clip_next  = clip_reg | sat_a.hit;
                mul_a      = MUL_A_W'(x_val);
                mul_b      = $signed({1'b0, mix_inv});
                state_next = srfm_pkg::ST_MIX_B;
            end

            srfm_pkg::ST_MIX_B:
            begin
                acc_next   = prod_reg;
                // wet part of the mix
                mul_a      = op_reg ? MUL_A_W'(high_output_reg[ch_reg])
                                    : MUL_A_W'(low_output_reg[ch_reg]);
                mul_b      = $signed({1'b0, mix_eff});
                state_next = srfm_pkg::ST_MIX_C;
            end

            srfm_pkg::ST_MIX_C:
            begin
                mix_total  = acc_reg + prod_reg + srfm_pkg::MIX_HALF;
                sat_o      = srfm_pkg::sat16(mix_total[PROD_W-1:2*FRAC_W]);
                res_next   = sat_o.val;
                clip_next  = clip_reg | sat_o.hit;
                state_next = srfm_pkg::ST_DONE;
            end

            srfm_pkg::ST_DONE:
            begin
                // hold here while the output register is still full
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = res_reg;
                    clipped_next    = clip_reg;
                    state_next      = srfm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srfm_pkg::ST_IDLE;
            end
        endcase
    end

    // coefficient writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cutoff_reg     <= '0;
            low_resonance_reg  <= '0;
            high_cutoff_reg    <= '0;
            high_resonance_reg <= '0;
            wet_mix_reg        <= srfm_pkg::MIX_ONE;
        end
        else if (cfg_write)
        begin
            case (srfm_pkg::reg_idx_t'(cfg_index))
                srfm_pkg::REG_LOW_CUTOFF:     low_cutoff_reg     <= cfg_data[srfm_pkg::COEF_W-1:0];
                srfm_pkg::REG_LOW_RESONANCE:  low_resonance_reg  <= $signed(cfg_data);
                srfm_pkg::REG_HIGH_CUTOFF:    high_cutoff_reg    <= cfg_data[srfm_pkg::COEF_W-1:0];
                srfm_pkg::REG_HIGH_RESONANCE: high_resonance_reg <= $signed(cfg_data);
                srfm_pkg::REG_WET_MIX:        wet_mix_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control, filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srfm_pkg::ST_IDLE;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                low_output_reg[i]    <= '0;
                low_momentum_reg[i]  <= '0;
                high_last_reg[i]     <= '0;
                high_output_reg[i]   <= '0;
                high_momentum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            clip_reg          <= clip_next;
            out_valid_reg     <= out_valid_next;
            low_output_reg    <= low_output_next;
            low_momentum_reg  <= low_momentum_next;
            high_last_reg     <= high_last_next;
            high_output_reg   <= high_output_next;
            high_momentum_reg <= high_momentum_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        ch_reg          <= ch_next;
        samp_reg        <= samp_next;
        diff_reg        <= diff_next;
        term_reg        <= term_next;
        acc_reg         <= acc_next;
        res_reg         <= res_next;
        sample_out_reg  <= sample_out_next;
        clipped_reg     <= clipped_next;
        prod_reg        <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // an accepted transaction always starts the sequencer
    `SRFM_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == srfm_pkg::ST_START, "accepted transaction did not start the sequencer")

    // bypass goes straight to the result and leaves the channel state alone
    `SRFM_ASSERT_NEXT(a_bypass_keeps_state, (state_reg == srfm_pkg::ST_START) && bypass, (state_reg == srfm_pkg::ST_DONE) && !clip_reg && $stable(low_output_reg[ch_reg]) && $stable(low_momentum_reg[ch_reg]) && $stable(high_output_reg[ch_reg]) && $stable(high_momentum_reg[ch_reg]), "bypass touched filter state")

    // a finished result waits while the output register is still full
    `SRFM_ASSERT_NEXT(a_result_waits, (state_reg == srfm_pkg::ST_DONE) && out_valid_reg && !out_ready, state_reg == srfm_pkg::ST_DONE, "result overwrote a pending output")

    // the input side is closed while an item is in flight
    `SRFM_ASSERT_NOW(a_busy_not_ready, state_reg != srfm_pkg::ST_IDLE, !in_ready, "input accepted while busy")

endmodule
